/* rtl/huf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package huf_pkg;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_SYMBOL   = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    // results kept per item, bits per message byte, code field width
    localparam int MAX_RES   = 8;
    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 16;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load_ins;
        logic load_dec;
        logic step_ins;
        logic step_dec;
        logic pop;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic ins_done;
        logic dec_done;
        logic dec_has_res;
        logic out_last;
    } sts_t;

endpackage

`default_nettype wire

/* rtl/huf_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface huf_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  symbol;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [7:0]  message_byte;

    modport source (output valid, kind, symbol, code_bits, code_length, message_byte,
                    input ready);
    modport sink   (input valid, kind, symbol, code_bits, code_length, message_byte,
                    output ready);
endinterface

`default_nettype wire

/* rtl/huf_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface huf_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] decoded_symbol;
    logic [1:0] status;
    logic       last;

    modport source (output valid, decoded_symbol, status, last, input ready);
    modport sink   (input valid, decoded_symbol, status, last, output ready);
endinterface

`default_nettype wire

/* rtl/huf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module huf_ctrl
    import huf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic kind,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_INSERT)
                    begin
                        cmd.load_ins = 1'b1;
                        state_next   = S_INS;
                    end
                    else
                    begin
                        cmd.load_dec = 1'b1;
                        state_next   = S_DEC;
                    end
                end
            end
            S_INS:
            begin
                cmd.step_ins = 1'b1;
                if (sts.ins_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_DEC:
            begin
                cmd.step_dec = 1'b1;
                if (sts.dec_done)
                begin
                    state_next = sts.dec_has_res ? S_OUT : S_IDLE;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.pop = 1'b1;
                    if (sts.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/huf_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module huf_dp
    import huf_pkg::*;
#(
    parameter int NODE_COUNT      = 512,
    parameter int MAX_CODE_LENGTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    input  wire logic [7:0]        symbol,
    input  wire logic [CODE_W-1:0] code_bits,
    input  wire logic [4:0]        code_length,
    input  wire logic [7:0]        message_byte,
    output logic [7:0]             decoded_symbol,
    output logic [1:0]             status,
    output logic                   last
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
    localparam int WW = 2 * NW + 8;

    // node word: {left child, right child, symbol}
    logic [WW-1:0] mem [NODE_COUNT];
    logic [WW-1:0] rdata_reg;
    logic [WW-1:0] root_reg;
    logic [WW-1:0] root_next;

    logic [NW-1:0] walk_reg, walk_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW:0]   free_reg, free_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [CODE_W-1:0] code_reg;
    logic [7:0]    sym_reg;
    logic [7:0]    byte_reg, byte_next;
    logic [2:0]    bit_reg, bit_next;
    logic [NW-1:0] clr_reg;
    logic [3:0]    cnt_reg, cnt_next;
    logic [2:0]    idx_reg, idx_next;
    logic [7:0]    res_sym_reg [MAX_RES];
    logic [1:0]    res_st_reg [MAX_RES];

    logic          we;
    logic [NW-1:0] waddr;
    logic [WW-1:0] wdata;

    logic [LW-1:0] len_c;
    logic [5:0]    pos_m1;
    logic          code_bit;
    logic [NW-1:0] w_left, w_right;
    logic [7:0]    w_sym;
    logic [NW-1:0] slot;
    logic          leaf;
    logic [WW-1:0] base;
    logic [NW-1:0] child;
    logic          a_v, b_v;
    logic [7:0]    a_sym;
    logic [1:0]    a_st, b_st;
    logic          f_v, s_v;
    logic [7:0]    f_sym;
    logic [1:0]    f_st;
    logic [3:0]    cnt_p1;

    assign w_left  = rdata_reg[WW-1 -: NW];
    assign w_right = rdata_reg[NW+7 -: NW];
    assign w_sym   = rdata_reg[7:0];

    // clamp the code length
    always_comb
    begin
        if (32'(code_length) > MAX_CODE_LENGTH)
        begin
            len_c = LW'(MAX_CODE_LENGTH);
        end
        else
        begin
            len_c = LW'(code_length);
        end
    end

    // current code bit, bits above the code field read as zero
    assign pos_m1   = 6'(pos_reg) - 6'd1;
    assign code_bit = (pos_m1 < 6'(CODE_W)) ? code_reg[pos_m1[3:0]] : 1'b0;
    assign slot     = code_bit ? w_right : w_left;

    // decode step: leaf emits, then the walk restarts from the cached root
    assign leaf  = (walk_reg != '0) && (w_left == '0) && (w_right == '0);
    assign base  = leaf ? root_reg : rdata_reg;
    assign child = byte_reg[7] ? base[NW+7 -: NW] : base[WW-1 -: NW];

    // walk and results
    always_comb
    begin
        walk_next = walk_reg;
        cur_next  = cur_reg;
        free_next = free_reg;
        pos_next  = pos_reg;
        byte_next = byte_reg;
        bit_next  = bit_reg;
        we        = 1'b0;
        waddr     = walk_reg;
        wdata     = rdata_reg;
        a_v       = 1'b0;
        a_sym     = '0;
        a_st      = ST_SYMBOL;
        b_v       = 1'b0;
        b_st      = ST_MISSING;
        sts       = '0;
        sts.clear_done = (clr_reg == NW'(NODE_COUNT - 1));
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (cmd.load_ins)
        begin
            walk_next = '0;
            pos_next  = len_c;
        end
        else if (cmd.load_dec)
        begin
            walk_next = cur_reg;
            byte_next = message_byte;
            bit_next  = '0;
        end
        else if (cmd.step_ins)
        begin
            if (pos_reg == '0)
            begin
                we           = 1'b1;
                wdata        = {w_left, w_right, sym_reg};
                a_v          = 1'b1;
                a_st         = ST_INSERTED;
                sts.ins_done = 1'b1;
            end
            else if (slot == '0)
            begin
                if (free_reg == (NW+1)'(NODE_COUNT))
                begin
                    a_v          = 1'b1;
                    a_st         = ST_FULL;
                    sts.ins_done = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    if (code_bit)
                    begin
                        wdata = {w_left, free_reg[NW-1:0], w_sym};
                    end
                    else
                    begin
                        wdata = {free_reg[NW-1:0], w_right, w_sym};
                    end
                    free_next = free_reg + 1'b1;
                    walk_next = free_reg[NW-1:0];
                    pos_next  = pos_reg - 1'b1;
                end
            end
            else
            begin
                walk_next = slot;
                pos_next  = pos_reg - 1'b1;
            end
        end
        else if (cmd.step_dec)
        begin
            a_v   = leaf;
            a_sym = w_sym;
            a_st  = ST_SYMBOL;
            b_v   = (child == '0);
            b_st  = ST_MISSING;
            walk_next = child;
            byte_next = {byte_reg[6:0], 1'b0};
            bit_next  = bit_reg + 1'b1;
            if (bit_reg == 3'(BYTE_BITS - 1))
            begin
                sts.dec_done = 1'b1;
                cur_next     = child;
            end
        end
        sts.dec_has_res = (cnt_next != '0);
        sts.out_last    = (idx_reg == 3'(cnt_reg - 4'd1));
    end

    // pack up to two new results behind those already held
    assign f_v    = a_v || b_v;
    assign f_sym  = a_v ? a_sym : 8'd0;
    assign f_st   = a_v ? a_st : b_st;
    assign s_v    = a_v && b_v;
    assign cnt_p1 = cnt_reg + 4'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (cmd.load_ins || cmd.load_dec)
        begin
            cnt_next = '0;
            idx_next = '0;
        end
        else if (cmd.pop)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else if (f_v && (cnt_reg < 4'(MAX_RES)))
        begin
            if (s_v && (cnt_p1 < 4'(MAX_RES)))
            begin
                cnt_next = cnt_reg + 4'd2;
            end
            else
            begin
                cnt_next = cnt_p1;
            end
        end
    end

    // root word cache follows every write of node zero
    assign root_next = (we && (waddr == '0)) ? wdata : root_reg;

    // node table
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[walk_next];
    end

    // result store
    always_ff @(posedge clk)
    begin
        if (f_v && (cnt_reg < 4'(MAX_RES)))
        begin
            res_sym_reg[cnt_reg[2:0]] <= f_sym;
            res_st_reg[cnt_reg[2:0]]  <= f_st;
        end
        if (s_v && (cnt_p1 < 4'(MAX_RES)))
        begin
            res_sym_reg[cnt_p1[2:0]] <= 8'd0;
            res_st_reg[cnt_p1[2:0]]  <= b_st;
        end
        if (cmd.load_ins)
        begin
            code_reg <= code_bits;
            sym_reg  <= symbol;
        end
        pos_reg  <= pos_next;
        byte_reg <= byte_next;
        bit_reg  <= bit_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
            cur_reg  <= '0;
            free_reg <= (NW+1)'(1);
            clr_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            walk_reg <= walk_next;
            cur_reg  <= cur_next;
            free_reg <= free_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    assign decoded_symbol = res_sym_reg[idx_reg];
    assign status         = res_st_reg[idx_reg];
    assign last           = sts.out_last;

    // checks
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (free_reg <= (NW+1)'(NODE_COUNT)) && (free_reg != '0))
        else $error("node allocation count out of range");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(MAX_RES))
        else $error("result count above limit");

    a_walk_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, walk_reg} < free_reg) && ({1'b0, cur_reg} < free_reg))
        else $error("walk reached an unallocated node");

    a_free_grows: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.step_ins |=> $stable(free_reg))
        else $error("node allocated outside an insert");

endmodule

`default_nettype wire

/* rtl/huffman_tree_decoder_unit.sv */
// insert: a tree walk with one read of the node table per code bit
// decode: one node table read per message bit
// each result then takes one output transfer; a decode with no result returns to idle at once
// items are taken one at a time; results leave the result store before the next item
// after reset the node table is cleared one entry a cycle, every entry, before any item
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_decoder_unit
    import huf_pkg::*;
#(
    parameter int NODE_COUNT      = 512,
    parameter int MAX_CODE_LENGTH = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    huf_item_if.sink      item,
    huf_result_if.source  result
);

    cmd_t cmd;
    sts_t sts;

    // controller
    huf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .kind      (item.kind),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // node table, walk and result store
    huf_dp #(
        .NODE_COUNT      (NODE_COUNT),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .symbol         (item.symbol),
        .code_bits      (item.code_bits),
        .code_length    (item.code_length),
        .message_byte   (item.message_byte),
        .decoded_symbol (result.decoded_symbol),
        .status         (result.status),
        .last           (result.last)
    );

endmodule

`default_nettype wire

/* sim/huffman_tree_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module huffman_tree_decoder_unit_tb;
    import huf_pkg::*;

    localparam int NODES       = 512;
    localparam int MAX_LEN     = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DUE_DEPTH   = 4096;

    typedef struct packed {
        logic [7:0] decoded_symbol;
        logic [1:0] status;
        logic       last;
    } tree_result_t;

    logic clk;
    logic rst_n;

    huf_item_if   item_ch ();
    huf_result_if result_ch ();

    huffman_tree_decoder_unit #(
        .NODE_COUNT      (NODES),
        .MAX_CODE_LENGTH (MAX_LEN)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // shadow copy of the node table
    logic [8:0] left_of   [NODES];
    logic [8:0] right_of  [NODES];
    logic [7:0] sym_of    [NODES];
    int         free_node;
    logic [8:0] walk_node;

    // expected results, written at the item transfer and read by the checker
    tree_result_t due_mem [DUE_DEPTH];
    int due_wr = 0;
    int due_rd = 0;

    bit errors_seen = 1'b0;
    bit quiet_mode;
    int items_sent;
    int results_seen = 0;
    int table_full_seen;
    int stall_left = 0;
    int cycles = 0;

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[huffman_tree_decoder_unit] ERROR");
            $finish;
        end
    end

    // add one expected result
    function automatic void due_add(input tree_result_t r);
        due_mem[due_wr % DUE_DEPTH] = r;
        due_wr++;
    endfunction

    // insert walk: allocate missing nodes, store symbol at the end
    function automatic void tree_insert(input logic [7:0] sym, input logic [15:0] code,
                                        input logic [4:0] len);
        int         steps;
        logic [8:0] node;
        logic [8:0] nxt;
        logic       bitv;
        logic [1:0] st;
        tree_result_t r;
        steps = (len > MAX_LEN) ? MAX_LEN : len;
        node  = '0;
        st    = ST_INSERTED;
        for (int i = 0; i < steps; i++)
        begin
            bitv = code[steps - 1 - i];
            nxt  = bitv ? right_of[node] : left_of[node];
            if (nxt == 0)
            begin
                if (free_node >= NODES)
                begin
                    st = ST_FULL;
                    break;
                end
                nxt = free_node[8:0];
                if (bitv)
                    right_of[node] = nxt;
                else
                    left_of[node] = nxt;
                free_node++;
            end
            node = nxt;
        end
        if (st == ST_INSERTED)
            sym_of[node] = sym;
        else
            table_full_seen++;
        r.decoded_symbol = '0;
        r.status         = st;
        r.last           = 1'b1;
        due_add(r);
    endfunction

    // decode walk over one byte, msb first, at most MAX_RES results kept
    function automatic void tree_decode(input logic [7:0] msg);
        int         n;
        logic [8:0] child;
        logic       bitv;
        tree_result_t r;
        n = 0;
        for (int b = 0; b < BYTE_BITS; b++)
        begin
            bitv = msg[BYTE_BITS - 1 - b];
            if (walk_node != 0 && left_of[walk_node] == 0 && right_of[walk_node] == 0)
            begin
                if (n < MAX_RES)
                begin
                    r.decoded_symbol = sym_of[walk_node];
                    r.status         = ST_SYMBOL;
                    r.last           = 1'b0;
                    due_add(r);
                end
                n++;
                walk_node = '0;
            end
            child = bitv ? right_of[walk_node] : left_of[walk_node];
            if (child == 0)
            begin
                if (n < MAX_RES)
                begin
                    r.decoded_symbol = '0;
                    r.status         = ST_MISSING;
                    r.last           = 1'b0;
                    due_add(r);
                end
                n++;
                walk_node = '0;
            end
            else
                walk_node = child;
        end
        if (n > 0)
            due_mem[(due_wr - 1) % DUE_DEPTH].last = 1'b1;
    endfunction

    // result check and output stalls
    always @(posedge clk)
    begin
        tree_result_t exp_r;
        int           r;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (due_rd == due_wr)
            begin
                $error("unexpected result: symbol %0d status %0d last %0d",
                       result_ch.decoded_symbol, result_ch.status, result_ch.last);
                errors_seen = 1'b1;
            end
            else
            begin
                exp_r = due_mem[due_rd % DUE_DEPTH];
                due_rd++;
                if (result_ch.decoded_symbol !== exp_r.decoded_symbol)
                begin
                    $error("decoded_symbol: expected %0d, got %0d",
                           exp_r.decoded_symbol, result_ch.decoded_symbol);
                    errors_seen = 1'b1;
                end
                if (result_ch.status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, result_ch.status);
                    errors_seen = 1'b1;
                end
                if (result_ch.last !== exp_r.last)
                begin
                    $error("last: expected %0d, got %0d", exp_r.last, result_ch.last);
                    errors_seen = 1'b1;
                end
            end
        end
        if (!rst_n)
        begin
            stall_left = 0;
            result_ch.ready <= 1'b0;
        end
        else if (quiet_mode)
        begin
            stall_left = 0;
            result_ch.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                result_ch.ready <= 1'b1;
            else
            begin
                stall_left = (r < 19) ? $urandom_range(0, 2) : $urandom_range(9, 29);
                result_ch.ready <= 1'b0;
            end
        end
    end

    // one item transfer, prediction taken at the accepting edge
    task automatic send_item(input logic k, input logic [7:0] sym, input logic [15:0] code,
                             input logic [4:0] len, input logic [7:0] msg);
        int gap;
        int r;
        gap = 0;
        if (!quiet_mode)
        begin
            r = $urandom_range(0, 19);
            if (r >= 17)
                gap = (r == 19) ? $urandom_range(10, 30) : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= k;
        item_ch.symbol       <= sym;
        item_ch.code_bits    <= code;
        item_ch.code_length  <= len;
        item_ch.message_byte <= msg;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (k == KIND_INSERT)
            tree_insert(sym, code, len);
        else
            tree_decode(msg);
        items_sent++;
    endtask

    task automatic send_insert(input logic [7:0] sym, input logic [15:0] code,
                               input logic [4:0] len);
        send_item(KIND_INSERT, sym, code, len, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_decode(input logic [7:0] msg);
        send_item(KIND_DECODE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  5'($urandom_range(0, 31)), msg);
    endtask

    // empty tree, leaves, overflow of one byte, interior symbols, long codes
    task automatic test_directed;
        send_decode(8'h00);
        send_insert(8'hFF, 16'h0000, 5'd0);
        send_insert(8'h41, 16'h0000, 5'd1);
        send_decode(8'h00);
        send_decode(8'h7F);
        send_insert(8'h42, 16'h0002, 5'd2);
        send_insert(8'h43, 16'h0003, 5'd2);
        send_insert(8'h44, 16'h0001, 5'd1);
        send_decode(8'hB4);
        send_decode(8'h5A);
        send_insert(8'h5A, 16'hFFFF, 5'd31);
        send_insert(8'h00, 16'h8001, 5'd20);
        send_insert(8'h00, 16'hFFFF, 5'd16);
        send_insert(8'hA5, 16'h0000, 5'd16);
        send_decode(8'hFF);
        send_decode(8'hFF);
        send_decode(8'h00);
        send_decode(8'h00);
        send_decode(8'hC3);
    endtask

    // mostly decode traffic over a tree grown by short codes
    task automatic test_random_traffic;
        int         r;
        logic [4:0] len;
        for (int blk = 0; blk < 6; blk++)
        begin
            quiet_mode = (blk % 3 == 2);
            for (int i = 0; i < 38; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                begin
                    if (r < 19)
                        len = 5'($urandom_range(1, 6));
                    else if (r < 23)
                        len = 5'($urandom_range(7, 16));
                    else
                        len = (r == 23) ? 5'd0 : 5'($urandom_range(17, 31));
                    send_insert(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                                len);
                end
                else
                    send_decode(8'($urandom_range(0, 255)));
            end
        end
        quiet_mode = 1'b0;
    endtask

    // long codes until the node table runs out, then a few decodes
    task automatic test_table_full;
        int n;
        n = 0;
        while ((free_node < NODES || table_full_seen < 3) && n < 80)
        begin
            send_insert(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 5'd16);
            n++;
        end
        for (int i = 0; i < 6; i++)
            send_decode(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        for (int i = 0; i < NODES; i++)
        begin
            left_of[i]  = '0;
            right_of[i] = '0;
            sym_of[i]   = '0;
        end
        free_node       = 1;
        walk_node       = '0;
        quiet_mode      = 1'b0;
        items_sent      = 0;
        table_full_seen = 0;
        rst_n           = 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.kind         <= KIND_INSERT;
        item_ch.symbol       <= '0;
        item_ch.code_bits    <= '0;
        item_ch.code_length  <= '0;
        item_ch.message_byte <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic();
        test_table_full();
        item_ch.valid <= 1'b0;

        // drain
        while (due_rd != due_wr)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d items, %0d results checked, %0d table-full inserts",
                 items_sent, results_seen, table_full_seen);
        $display("nodes in use at the end: %0d of %0d", free_node, NODES);
        if (!errors_seen && due_rd == due_wr)
            $display("[huffman_tree_decoder_unit] OK");
        else
            $display("[huffman_tree_decoder_unit] ERROR");
        $finish;
    end

endmodule
